// ===== hw/rtl/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared codes, widths and control types for the positional list block.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

   // Default list capacity; the top level hands it down as a parameter.
   localparam int PIDL_CAPACITY = 16;

   // Fixed field widths of the command and result channels.
   localparam int CMD_W        = 2;
   localparam int POS_W        = 8;
   localparam int DATA_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int LIST_COUNT_W = 7;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REWRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SHOW    = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;        // capture the request fields
      logic                do_insert;   // open a slot at the position and write
      logic                do_delete;   // close the slot at the position
      logic                do_rewrite;  // overwrite the entry at the position
      logic                emit;        // load the result registers
      logic [STATUS_W-1:0] emit_status;
      logic                emit_elem;   // result carries the read entry, else zero
      logic                emit_last;
      logic                show_sel;    // read port follows the show index
      logic                idx_clear;
      logic                idx_inc;
   } pidl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] command;    // captured command code
      logic             pos_ok;     // position within 1..count
      logic             pos_ok_ins; // position within 1..count+1
      logic             full;
      logic             empty;
      logic             show_last;  // show index points at the final entry
   } pidl_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pidl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidl_ctrl
// Controller state machine: sequences one command at a time and drives the
// result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_ctrl
   import pidl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output      logic          busy,
   output      logic          rsp_valid,
   output      pidl_cmd_type  cmd,
   input  wire pidl_stat_type stat
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SHOW = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in       = ST_IDLE;
            cmd.emit       = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_status = STATUS_OK;
            unique case (stat.command)
               CMD_INSERT: begin
                  priority if (!stat.pos_ok_ins) begin
                     cmd.emit_status = STATUS_BAD_POS;
                  end else if (stat.full) begin
                     cmd.emit_status = STATUS_FULL;
                  end else begin
                     cmd.do_insert = 1'b1;
                  end
               end
               CMD_DELETE: begin
                  if (!stat.pos_ok) begin
                     cmd.emit_status = STATUS_BAD_POS;
                  end else begin
                     cmd.do_delete = 1'b1;
                     cmd.emit_elem = 1'b1;
                  end
               end
               CMD_REWRITE: begin
                  if (!stat.pos_ok) begin
                     cmd.emit_status = STATUS_BAD_POS;
                  end else begin
                     cmd.do_rewrite = 1'b1;
                  end
               end
               CMD_SHOW: begin
                  if (stat.empty) begin
                     cmd.emit_status = STATUS_EMPTY;
                  end else begin
                     cmd.emit      = 1'b0;
                     cmd.emit_last = 1'b0;
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_SHOW;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SHOW: begin
            cmd.show_sel    = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_elem   = 1'b1;
            cmd.emit_status = STATUS_OK;
            cmd.emit_last   = stat.show_last;
            cmd.idx_inc     = 1'b1;
            if (stat.show_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign valid_in = cmd.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pidl_dp.sv =====
// ----------------------------------------------------------------------------
// pidl_dp
// Datapath: row of entry cells with shift paths, entry count, show index,
// position checks and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_dp
   import pidl_pkg::*;
#(
   parameter int CAPACITY = PIDL_CAPACITY
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_new_value,
   input  wire pidl_cmd_type             cmd,
   output      pidl_stat_type            stat,
   output      logic [STATUS_W-1:0]      rsp_status,
   output      logic signed [DATA_W-1:0] rsp_element,
   output      logic [LIST_COUNT_W-1:0]  rsp_list_count,
   output      logic                     rsp_last
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Captured request.
   logic [CMD_W-1:0]  command_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] value_ff;

   logic [DATA_W-1:0] cell_ff [CAPACITY];
   logic [DATA_W-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [STATUS_W-1:0]     status_ff;
   logic [DATA_W-1:0]       element_ff;
   logic [LIST_COUNT_W-1:0] list_count_ff;
   logic                    last_ff;

   logic [POS_W-1:0]  p0;      // zero-based position
   logic [IDX_W-1:0]  rd_idx;
   logic [DATA_W-1:0] rd_data;

   assign p0      = pos_ff - POS_W'(1);
   assign rd_idx  = cmd.show_sel ? idx_ff : p0[IDX_W-1:0];
   assign rd_data = cell_ff[rd_idx];

   assign stat.command    = command_ff;
   assign stat.pos_ok     = (pos_ff != '0) &&
                            ({1'b0, pos_ff} <= (POS_W+1)'(count_ff));
   assign stat.pos_ok_ins = (pos_ff != '0) &&
                            ({1'b0, pos_ff} <= (POS_W+1)'(count_ff) + (POS_W+1)'(1));
   assign stat.full       = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.show_last  = ((CNT_W+1)'(idx_ff) + (CNT_W+1)'(1)) == (CNT_W+1)'(count_ff);

   // Each cell picks from itself, its lower neighbor (insert), its upper
   // neighbor (delete) or the new value.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.do_insert) begin
            if (POS_W'(i) == p0) begin
               cell_in[i] = value_ff;
            end else if (POS_W'(i) > p0) begin
               if (i > 0) begin
                  cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end else if (cmd.do_delete) begin
            if ((POS_W'(i) >= p0) && (i < CAPACITY - 1)) begin
               cell_in[i] = cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end else if (cmd.do_rewrite) begin
            if (POS_W'(i) == p0) begin
               cell_in[i] = value_ff;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.do_delete) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      for (int k = 0; k < CAPACITY; k++) begin
         cell_ff[k] <= cell_in[k];
      end
      if (cmd.load) begin
         command_ff <= req_command;
         pos_ff     <= req_position;
         value_ff   <= req_new_value;
      end
      if (cmd.emit) begin
         status_ff     <= cmd.emit_status;
         element_ff    <= cmd.emit_elem ? rd_data : '0;
         list_count_ff <= LIST_COUNT_W'(count_in);
         last_ff       <= cmd.emit_last;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_element    = element_ff;
   assign rsp_list_count = list_count_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Fixed-capacity ordered list of signed 32-bit values with 1-based positions,
// supporting insert, delete, rewrite and show commands.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                 Transfer when
//   -------   ------------------------------------  ------------------------
//   command   start, busy, req_command,             start high, busy low
//             req_position, req_new_value
//   result    rsp_valid, rsp_status, rsp_element,   rsp_valid high (one cycle)
//             rsp_list_count, rsp_last
//
// Insert, delete and rewrite pass through a capture step, which registers the
// request, and an execute step, in which the cell row shifts or writes in
// place and the result register loads, before the next command is accepted.
// After these steps a show emits one entry per cycle through the single read
// port of the cell row; an empty show ends in the execute step. Reset clears the
// entry count and the controller; entry contents are not cleared. The
// result receiver cannot stall, so each result is held for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list
   import pidl_pkg::*;
#(
   parameter int CAPACITY = PIDL_CAPACITY
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_new_value,
   output      logic                     rsp_valid,
   output      logic [STATUS_W-1:0]      rsp_status,
   output      logic signed [DATA_W-1:0] rsp_element,
   output      logic [LIST_COUNT_W-1:0]  rsp_list_count,
   output      logic                     rsp_last
);

   // Command and status buses between the controller and the datapath.
   pidl_cmd_type  cmd;
   pidl_stat_type stat;

   // The controller walks each command through capture, execute and, for a
   // show, an emit step per stored entry. It owns the result strobe.
   pidl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the cell row, the count, the position checks and the
   // result payload registers, which load in the same cycle as the strobe.
   pidl_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_new_value  (req_new_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_element    (rsp_element),
      .rsp_list_count (rsp_list_count),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
